/* design/rblc_pkg.sv */
// ----------------------------------------------------------------------------
// rblc_pkg
// Shared types and constants for the ring buffer lag correlator.
// ----------------------------------------------------------------------------
package rblc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int INC_W    = PROD_W + 1;
  localparam int SUM_W    = 48;
  localparam int LAG_W    = 6;
  localparam int LAGS_DEF = 64;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register index of the one configuration register
  localparam logic REG_TWO_SIDED = 1'b0;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_READ = 1'b1
  } req_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic shift;      // latch products and move samples one cell towards the origin
    logic acc;        // fold the latched products into the lag sum
    logic two_sided;  // add the mirrored product as well
  } cell_ctrl_t;

endpackage

/* design/ring_buffer_lag_correlator.sv */
// ----------------------------------------------------------------------------
// ring_buffer_lag_correlator
// Streaming lag correlator over two signed 16-bit signals, built as a chain
// of cells. Cell k holds the k-th oldest sample pair and the sum for lag k.
//
//   port group | direction | handshake          | beat
//   in_        | input     | in_valid/in_stall  | push pair or read request
//   out_       | output    | out_valid/out_stall| one lag sum per read
//   cfg_       | input     | APB psel/penable   | two_sided register
//
// Pushes may follow each other in every cycle.
// After a push the lag sums settle through the product register, then the
// saturating add, so a read right behind a push is stalled while they settle.
// A read result sits in an output register; further pushes still enter.
// Reset (synchronous, rst_n low) clears samples, sums and flags.
// ----------------------------------------------------------------------------
module ring_buffer_lag_correlator #(
  parameter int LAGS = rblc_pkg::LAGS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_req_type,
  input  logic signed [rblc_pkg::SAMPLE_W-1:0]   in_sample_a,
  input  logic signed [rblc_pkg::SAMPLE_W-1:0]   in_sample_b,
  input  logic [rblc_pkg::LAG_W-1:0]             in_read_lag,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [rblc_pkg::LAG_W-1:0]             out_lag_index,
  output logic signed [rblc_pkg::SUM_W-1:0]      out_lag_sum,
  output logic                                   out_saturated,
  // configuration
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [rblc_pkg::CFG_AW-1:0]            cfg_paddr,
  input  logic [rblc_pkg::CFG_DW-1:0]            cfg_pwdata,
  output logic [rblc_pkg::CFG_DW-1:0]            cfg_prdata,
  output logic                                   cfg_pready
);
  import rblc_pkg::*;

  localparam int SEL_W = $clog2(LAGS);
  localparam int RW_A  = $clog2(LAGS + 1);
  localparam int RW    = (RW_A > LAG_W) ? RW_A : LAG_W;

  // configuration
  logic two_sided_r;
  logic cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_sided_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_idx == REG_TWO_SIDED) begin
      two_sided_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_idx == REG_TWO_SIDED) begin
      cfg_prdata[0] = two_sided_r;
    end
  end

  // handshake
  logic       acc_pending_r;
  logic       out_valid_r;
  logic       push_acc, read_acc;
  req_t       req;
  cell_ctrl_t ctrl;

  assign req      = req_t'(in_req_type);
  // hold reads while sums settle or the result register is blocked
  assign in_stall = (req == REQ_READ) && (acc_pending_r || (out_valid_r && out_stall));
  assign push_acc = in_valid && !in_stall && req == REQ_PUSH;
  assign read_acc = in_valid && !in_stall && req == REQ_READ;

  assign ctrl.shift     = push_acc;
  assign ctrl.acc       = acc_pending_r;
  assign ctrl.two_sided = two_sided_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_pending_r <= 1'b0;
    end else begin
      acc_pending_r <= push_acc;
    end
  end

  // cell chain
  logic signed [SAMPLE_W-1:0] cell_a   [LAGS];
  logic signed [SAMPLE_W-1:0] cell_b   [LAGS];
  logic signed [SUM_W-1:0]    cell_sum [LAGS];
  logic                       cell_sat [LAGS];

  for (genvar k = 0; k < LAGS; k++) begin : g_cell
    logic signed [SAMPLE_W-1:0] nbr_a, nbr_b;
    if (k == LAGS - 1) begin : g_tail
      assign nbr_a = in_sample_a;
      assign nbr_b = in_sample_b;
    end else begin : g_mid
      assign nbr_a = cell_a[k+1];
      assign nbr_b = cell_b[k+1];
    end
    rblc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .origin_a (cell_a[0]),
      .origin_b (cell_b[0]),
      .nbr_a    (nbr_a),
      .nbr_b    (nbr_b),
      .a_q      (cell_a[k]),
      .b_q      (cell_b[k]),
      .sum_q    (cell_sum[k]),
      .sat_q    (cell_sat[k])
    );
  end

  // read selection
  logic [RW-1:0]           lag_ext;
  logic                    lag_ok;
  logic [SEL_W-1:0]        sel;
  logic signed [SUM_W-1:0] rd_sum;
  logic                    rd_sat;

  always_comb begin
    lag_ext = RW'(in_read_lag);
    lag_ok  = lag_ext < RW'(LAGS);
    sel     = lag_ext[SEL_W-1:0];
    rd_sum  = lag_ok ? cell_sum[sel] : '0;
    rd_sat  = lag_ok ? cell_sat[sel] : 1'b0;
  end

  // result register
  logic [LAG_W-1:0]        out_lag_index_r;
  logic signed [SUM_W-1:0] out_lag_sum_r;
  logic                    out_saturated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (read_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_acc) begin
      out_lag_index_r <= in_read_lag;
      out_lag_sum_r   <= rd_sum;
      out_saturated_r <= rd_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_lag_index = out_lag_index_r;
  assign out_lag_sum   = out_lag_sum_r;
  assign out_saturated = out_saturated_r;

endmodule

/* design/rblc_cell.sv */
// ----------------------------------------------------------------------------
// rblc_cell
// One cell of the correlator chain: holds one sample pair, its lag sum and
// sticky saturation flag. Products are registered before the saturating add.
// ----------------------------------------------------------------------------
module rblc_cell (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  rblc_pkg::cell_ctrl_t                        ctrl,
  input  logic signed [rblc_pkg::SAMPLE_W-1:0]        origin_a,
  input  logic signed [rblc_pkg::SAMPLE_W-1:0]        origin_b,
  input  logic signed [rblc_pkg::SAMPLE_W-1:0]        nbr_a,
  input  logic signed [rblc_pkg::SAMPLE_W-1:0]        nbr_b,
  output logic signed [rblc_pkg::SAMPLE_W-1:0]        a_q,
  output logic signed [rblc_pkg::SAMPLE_W-1:0]        b_q,
  output logic signed [rblc_pkg::SUM_W-1:0]           sum_q,
  output logic                                        sat_q
);
  import rblc_pkg::*;

  logic signed [SAMPLE_W-1:0] a_r, b_r;
  logic signed [PROD_W-1:0]   p1_r, p2_r;
  logic signed [PROD_W-1:0]   p1_nxt, p2_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic                       sat_r, sat_nxt;
  logic signed [INC_W-1:0]    inc;
  logic signed [SUM_W:0]      wide;

  always_comb begin
    p1_nxt = origin_a * b_r;
    p2_nxt = '0;
    if (ctrl.two_sided) begin
      p2_nxt = a_r * origin_b;
    end
  end

  always_comb begin
    inc     = INC_W'(p1_r) + INC_W'(p2_r);
    wide    = (SUM_W + 1)'(sum_r) + (SUM_W + 1)'(inc);
    sum_nxt = wide[SUM_W-1:0];
    sat_nxt = sat_r;
    // clamp when the two top bits disagree
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      sat_nxt = 1'b1;
      sum_nxt = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r   <= '0;
      b_r   <= '0;
      sum_r <= '0;
      sat_r <= 1'b0;
    end else begin
      if (ctrl.shift) begin
        a_r <= nbr_a;
        b_r <= nbr_b;
      end
      if (ctrl.acc) begin
        sum_r <= sum_nxt;
        sat_r <= sat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
  end

  assign a_q   = a_r;
  assign b_q   = b_r;
  assign sum_q = sum_r;
  assign sat_q = sat_r;

endmodule

/* tb/tb_ring_buffer_lag_correlator.sv */
// ----------------------------------------------------------------------------
// tb_ring_buffer_lag_correlator
// Self-checking bench for the lag correlator. A scoreboard keeps its own
// copy of the sample rings, the lag sums and the sticky saturation flags.
// It predicts every read beat at the moment the request is accepted. The
// bench runs directed corner pushes and reads, then random traffic under
// both correlation modes with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_ring_buffer_lag_correlator;
  import rblc_pkg::*;

  localparam int LAGS          = LAGS_DEF;
  localparam int PHASE_ITEMS   = 200;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 4;

  localparam int REG_UNMAPPED = 1;
  localparam logic [CFG_AW-1:0] ADDR_TWO_SIDED = CFG_AW'(4 * int'(REG_TWO_SIDED));
  localparam logic [CFG_AW-1:0] ADDR_UNMAPPED  = CFG_AW'(4 * REG_UNMAPPED);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam longint SUM_HI = 64'sh0000_7fff_ffff_ffff;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct packed {
    logic [LAG_W-1:0]        lag;
    logic signed [SUM_W-1:0] sum;
    logic                    sat;
  } lag_result_t;

  class lag_sum_board;
    logic signed [SAMPLE_W-1:0] ring_a [LAGS];
    logic signed [SAMPLE_W-1:0] ring_b [LAGS];
    logic [LAG_W-1:0]           origin;
    longint                     sums [LAGS];
    bit                         sat_flag [LAGS];
    bit                         two_sided;
    lag_result_t                awaited [$];
    int                         errors;

    function new();
      for (int k = 0; k < LAGS; k++) begin
        ring_a[k]   = '0;
        ring_b[k]   = '0;
        sums[k]     = 0;
        sat_flag[k] = 1'b0;
      end
      origin    = '0;
      two_sided = 1'b1;
      errors    = 0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) begin
        $display("MISMATCH at %0t: %s", $realtime, what);
      end
    endtask

    function void write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
      // anything outside the one register is dropped
      if (addr == ADDR_TWO_SIDED) begin
        two_sided = data[0];
      end
    endfunction

    function void note_input(req_t kind, logic signed [SAMPLE_W-1:0] a,
                             logic signed [SAMPLE_W-1:0] b, logic [LAG_W-1:0] lag);
      longint           a_org;
      longint           b_org;
      longint           step;
      longint           total;
      logic [LAG_W-1:0] slot;
      lag_result_t      r;
      if (kind == REQ_PUSH) begin
        a_org = ring_a[origin];
        b_org = ring_b[origin];
        for (int k = 0; k < LAGS; k++) begin
          slot = origin + LAG_W'(k);
          step = a_org * ring_b[slot];
          if (two_sided) begin
            step += ring_a[slot] * b_org;
          end
          // clamp once per lag and keep the flag sticky
          total = sums[k] + step;
          if (total > SUM_HI) begin
            total       = SUM_HI;
            sat_flag[k] = 1'b1;
          end else if (total < SUM_LO) begin
            total       = SUM_LO;
            sat_flag[k] = 1'b1;
          end
          sums[k] = total;
        end
        ring_a[origin] = a;
        ring_b[origin] = b;
        origin         = origin + 1'b1;
      end else begin
        r.lag = lag;
        r.sum = SUM_W'(sums[lag]);
        r.sat = sat_flag[lag];
        awaited.push_back(r);
      end
    endfunction

    task check_result(logic [LAG_W-1:0] lag, logic signed [SUM_W-1:0] sum, logic sat);
      lag_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result beat for lag %0d with nothing outstanding", lag));
      end else begin
        want = awaited.pop_front();
        if (lag !== want.lag) begin
          report($sformatf("lag_index %0d, predicted %0d", lag, want.lag));
        end
        if (sum !== want.sum) begin
          report($sformatf("lag %0d: lag_sum %0d, predicted %0d", want.lag, sum, want.sum));
        end
        if (sat !== want.sat) begin
          report($sformatf("lag %0d: saturated %b, predicted %b", want.lag, sat, want.sat));
        end
      end
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_req_type;
  logic signed [SAMPLE_W-1:0] in_sample_a;
  logic signed [SAMPLE_W-1:0] in_sample_b;
  logic [LAG_W-1:0]           in_read_lag;
  logic                       out_valid;
  logic                       out_stall;
  logic [LAG_W-1:0]           out_lag_index;
  logic signed [SUM_W-1:0]    out_lag_sum;
  logic                       out_saturated;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [CFG_AW-1:0]          cfg_paddr;
  logic [CFG_DW-1:0]          cfg_pwdata;
  logic [CFG_DW-1:0]          cfg_prdata;
  logic                       cfg_pready;

  lag_sum_board sb;
  bit           no_idle;
  bit           long_hold;
  int           quiet_cycles;

  ring_buffer_lag_correlator #(.LAGS(LAGS)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_lag_index, out_lag_sum, out_saturated);
      end
      if (in_valid && !in_stall) begin
        sb.note_input(req_t'(in_req_type), in_sample_a, in_sample_b, in_read_lag);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // result side: random hold-off before each beat, one long hold on request
  initial begin : result_sink
    int unsigned gap;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 7);
      out_stall = (gap != 0);
      repeat (gap) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // call at a falling edge; returns at the falling edge after the beat
  task automatic send_item(req_t kind, logic signed [SAMPLE_W-1:0] a,
                           logic signed [SAMPLE_W-1:0] b, logic [LAG_W-1:0] lag);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_req_type = kind;
    in_sample_a = a;
    in_sample_b = b;
    in_read_lag = lag;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    // let the last push settle into the sums
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(addr, data);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic set_mode(bit sided);
    logic [CFG_DW-1:0] data;
    logic [CFG_DW-1:0] back;
    data = ($urandom & ~32'd1) | CFG_DW'(sided);
    cfg_write(ADDR_TWO_SIDED, data);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = ADDR_TWO_SIDED;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    back = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (back !== CFG_DW'(sided)) begin
      sb.report($sformatf("two_sided reads back %0h, wrote %0d", back, sided));
    end
    // write to an unmapped index must leave the mode alone
    cfg_write(ADDR_UNMAPPED, ~data);
  endtask

  initial begin : stimulus
    req_t kind;
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = REQ_PUSH;
    in_sample_a  = '0;
    in_sample_b  = '0;
    in_read_lag  = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    no_idle      = 1'b1;
    long_hold    = 1'b0;
    quiet_cycles = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // corners, back-to-back, reset mode is two-sided
    cfg_write(ADDR_UNMAPPED, '0);
    send_item(REQ_PUSH, SAMPLE_MAX, SAMPLE_MAX, '0);
    send_item(REQ_PUSH, SAMPLE_MIN, SAMPLE_MIN, 6'd63);
    send_item(REQ_PUSH, SAMPLE_MIN, SAMPLE_MAX, '0);
    send_item(REQ_PUSH, SAMPLE_MAX, SAMPLE_MIN, '0);
    send_item(REQ_READ, '0, '0, 6'd0);
    send_item(REQ_READ, SAMPLE_MAX, SAMPLE_MIN, 6'd63);
    send_item(REQ_READ, '0, '0, 6'd1);
    send_item(REQ_PUSH, -16'sd1, 16'sd1, '0);
    send_item(REQ_PUSH, 16'sh5555, 16'shaaaa, 6'h2a);
    send_item(REQ_PUSH, 16'shaaaa, 16'sh5555, 6'h15);
    send_item(REQ_READ, '0, '0, 6'd2);
    send_item(REQ_READ, '0, '0, 6'd3);
    send_item(REQ_PUSH, '0, '0, '0);
    send_item(REQ_READ, '0, '0, 6'd0);
    send_item(REQ_READ, '0, '0, 6'd62);
    send_item(REQ_READ, '0, '0, 6'd32);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      set_mode(phase[0]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        no_idle = (i % 100) >= 70;
        if (phase == 1 && i == 0) begin
          long_hold = 1'b1;
        end
        if (phase == 2 && i == PHASE_ITEMS / 2) begin
          wait_drained();
        end
        kind = ($urandom_range(0, 9) < 6) ? REQ_PUSH : REQ_READ;
        send_item(kind, rand_sample(), rand_sample(), LAG_W'($urandom));
      end
      wait_drained();
    end

    if (sb.awaited.size() != 0) begin
      sb.report($sformatf("%0d read beats never returned", sb.awaited.size()));
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
